[sv/wavelet_coefficient_shrinkage_defines.svh]
// ----------------------------------------------------------------------------
// Wavelet coefficient shrinkage - assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WAVELET_COEFFICIENT_SHRINKAGE_DEFINES_SVH
`define WAVELET_COEFFICIENT_SHRINKAGE_DEFINES_SVH

// same-cycle implication
`define WCS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WCS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/wcs_pkg.sv]
// ----------------------------------------------------------------------------
// Wavelet coefficient shrinkage - package
// Widths, register codes, reset values and shared types.
// ----------------------------------------------------------------------------
package wcs_pkg;

	localparam int COEF_W     = 16;
	localparam int POS_W      = 12;
	localparam int DIM_W      = 13;
	localparam int LVL_W      = 4;
	localparam int THR_W      = 11;
	localparam int MODE_W     = 2;
	localparam int FRAC_BITS  = 4;
	localparam int MAG_W      = COEF_W;
	localparam int T_W        = THR_W + FRAC_BITS;
	localparam int SQ_W       = 2 * T_W;
	localparam int Q_W        = T_W;
	localparam int REM_W      = MAG_W + 1;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = COEF_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = DIM_W;

	localparam logic [DIM_W-1:0]  RST_WIDTH  = DIM_W'(512);
	localparam logic [DIM_W-1:0]  RST_HEIGHT = DIM_W'(512);
	localparam logic [LVL_W-1:0]  RST_LEVEL  = LVL_W'(1);
	localparam logic [THR_W-1:0]  RST_THRESH = THR_W'(20);

	typedef enum logic [MODE_W-1:0] {
		MODE_HARD    = 2'd0,
		MODE_SOFT    = 2'd1,
		MODE_GARROTE = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH  = 3'd0,
		CFG_HEIGHT = 3'd1,
		CFG_LEVEL  = 3'd2,
		CFG_THRESH = 3'd3,
		CFG_MODE   = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [DIM_W-1:0]  width;
		logic [DIM_W-1:0]  height;
		logic [LVL_W-1:0]  level;
		logic [THR_W-1:0]  thresh;
		logic [MODE_W-1:0] mode;
	} cfg_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] raw;
		logic                     neg;
		logic [MAG_W-1:0]         mag;
		logic [T_W-1:0]           thr;
		logic [MODE_W-1:0]        mode;
		logic                     detail;
		logic                     gt;
	} item_t;

endpackage

[sv/wcs_front.sv]
// ----------------------------------------------------------------------------
// Wavelet coefficient shrinkage - front stages
// Band classification, magnitude and threshold compare; threshold square.
// ----------------------------------------------------------------------------
module wcs_front import wcs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [IN_DATA_W-1:0] in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output item_t                out_item,
	output logic [SQ_W-1:0]      out_sq
);

	logic               v_s1, v_s2;
	logic               ld_s1, ld_s2;
	item_t              item_s1, item_s2;
	logic [SQ_W-1:0]    sq_s2;
	item_t              item_c;
	logic [POS_W-1:0]   col_c, row_c;
	logic [DIM_W-1:0]   wlim_c, hlim_c;

	assign ld_s2    = !v_s2 || out_ready;
	assign ld_s1    = !v_s1 || ld_s2;
	assign in_ready = ld_s1;

	always_comb begin
		col_c          = in_data[COEF_W+POS_W-1:COEF_W];
		row_c          = in_data[COEF_W+2*POS_W-1:COEF_W+POS_W];
		wlim_c         = cfg.width >> cfg.level;
		hlim_c         = cfg.height >> cfg.level;
		item_c.raw     = in_data[COEF_W-1:0];
		item_c.neg     = in_data[COEF_W-1];
		item_c.mag     = item_c.neg ? MAG_W'(-item_c.raw) : MAG_W'(item_c.raw);
		item_c.thr     = {cfg.thresh, FRAC_BITS'(0)};
		item_c.mode    = cfg.mode;
		item_c.detail  = ({1'b0, col_c} >= wlim_c) || ({1'b0, row_c} >= hlim_c);
		item_c.gt      = item_c.mag > {1'b0, item_c.thr};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ld_s1) v_s1 <= in_valid;
			if (ld_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1 && in_valid) item_s1 <= item_c;
		if (ld_s2 && v_s1) begin
			item_s2 <= item_s1;
			sq_s2   <= SQ_W'(item_s1.thr) * SQ_W'(item_s1.thr);
		end
	end

	assign out_valid = v_s2;
	assign out_item  = item_s2;
	assign out_sq    = sq_s2;

endmodule

[sv/wcs_div.sv]
// ----------------------------------------------------------------------------
// Wavelet coefficient shrinkage - pipelined divider
// Restoring division of the squared threshold by the magnitude,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module wcs_div import wcs_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  item_t           in_item,
	input  logic [SQ_W-1:0] in_sq,
	output logic            out_valid,
	input  logic            out_ready,
	output item_t           out_item,
	output logic [Q_W-1:0]  out_quot
);

	logic              v_s3    [Q_W];
	logic              ld      [Q_W];
	logic [REM_W-1:0]  rem_s3  [Q_W];
	logic [Q_W-1:0]    quot_s3 [Q_W];
	logic [SQ_W-1:0]   sq_s3   [Q_W];
	item_t             item_s3 [Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_bit
		logic              v_in;
		logic              ld_nxt;
		logic [REM_W-1:0]  rem_in;
		logic [Q_W-1:0]    quot_in;
		logic [SQ_W-1:0]   sq_in;
		item_t             item_in;
		logic [REM_W-1:0]  trial;
		logic              ge;

		if (k == 0) begin : g_head
			assign v_in    = in_valid;
			assign rem_in  = REM_W'(in_sq[SQ_W-1:Q_W]);
			assign quot_in = '0;
			assign sq_in   = in_sq;
			assign item_in = in_item;
		end else begin : g_body
			assign v_in    = v_s3[k-1];
			assign rem_in  = rem_s3[k-1];
			assign quot_in = quot_s3[k-1];
			assign sq_in   = sq_s3[k-1];
			assign item_in = item_s3[k-1];
		end

		if (k == Q_W - 1) begin : g_tail
			assign ld_nxt = out_ready;
		end else begin : g_mid
			assign ld_nxt = ld[k+1];
		end

		assign ld[k] = !v_s3[k] || ld_nxt;
		assign trial = {rem_in[REM_W-2:0], sq_in[Q_W-1-k]};
		assign ge    = trial >= REM_W'(item_in.mag);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s3[k] <= 1'b0;
			end else if (ld[k]) begin
				v_s3[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (ld[k] && v_in) begin
				rem_s3[k]  <= ge ? trial - REM_W'(item_in.mag) : trial;
				quot_s3[k] <= {quot_in[Q_W-2:0], ge};
				sq_s3[k]   <= sq_in;
				item_s3[k] <= item_in;
			end
		end
	end

	assign in_ready  = ld[0];
	assign out_valid = v_s3[Q_W-1];
	assign out_item  = item_s3[Q_W-1];
	assign out_quot  = quot_s3[Q_W-1];

endmodule

[sv/wcs_back.sv]
// ----------------------------------------------------------------------------
// Wavelet coefficient shrinkage - result stage
// Applies the shrink rule, restores the sign and holds the output register.
// ----------------------------------------------------------------------------
`include "wavelet_coefficient_shrinkage_defines.svh"

module wcs_back import wcs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  item_t                 in_item,
	input  logic [Q_W-1:0]        in_quot,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_DATA_W-1:0] out_data,
	output logic                  out_detail
);

	logic                 v_s4;
	logic                 ld_s4;
	logic                 load;
	logic [COEF_W-1:0]    coef_s4;
	logic                 detail_s4;
	logic [MAG_W-1:0]     m_c;
	logic [COEF_W-1:0]    res_c;
	logic [MAG_W-1:0]     omag;

	assign ld_s4    = !v_s4 || out_ready;
	assign in_ready = ld_s4;
	assign load     = ld_s4 && in_valid;

	always_comb begin
		m_c = '0;
		if (in_item.gt) begin
			case (mode_t'(in_item.mode))
				MODE_SOFT:    m_c = in_item.mag - MAG_W'(in_item.thr);
				MODE_GARROTE: m_c = in_item.mag - MAG_W'(in_quot);
				default:      m_c = in_item.mag;
			endcase
		end
		res_c = in_item.neg ? COEF_W'(-m_c) : COEF_W'(m_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (ld_s4) begin
			v_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			coef_s4   <= in_item.detail ? res_c : COEF_W'(in_item.raw);
			detail_s4 <= in_item.detail;
		end
	end

	assign out_valid  = v_s4;
	assign out_data   = coef_s4;
	assign out_detail = detail_s4;
	assign omag       = coef_s4[COEF_W-1] ? MAG_W'(-coef_s4) : coef_s4;

	// garrote correction t*t/|c| stays below t when |c| > t > 0
	`WCS_ASSERT_NOW(a_quot_below_thr, in_valid && in_item.gt && (in_item.thr != '0), in_quot < in_item.thr, "quotient not below threshold")
	`WCS_ASSERT_NEXT(a_mag_no_grow, load && in_item.detail, omag <= $past(in_item.mag), "shrunk magnitude grew")
	`WCS_ASSERT_NEXT(a_small_zeroed, load && in_item.detail && !in_item.gt, coef_s4 == '0, "small detail not zeroed")

endmodule

[sv/wavelet_coefficient_shrinkage.sv]
// ----------------------------------------------------------------------------
// Wavelet coefficient shrinkage - top level
// Hard, soft and garrote thresholding of 2D wavelet detail coefficients.
// ----------------------------------------------------------------------------
//  channel   dir   handshake              payload
//  s_axis    in    s_axis_tvalid/tready   tdata: coef_in, col, row
//  m_axis    out   m_axis_tvalid/tready   tdata: coef_out; tuser: is_detail
//  cfg       in    cfg_we                 cfg_index, cfg_data
//
//  One coefficient per cycle unless m_axis_tready stalls it; two front stages,
//  fifteen divider stages (one quotient bit each), one output register.
//  Reset clears all stage valid bits and loads the register defaults.
//  m_axis_tready low holds occupied stages; empty stages still fill, so the
//  input keeps taking transfers until the pipeline is full.
// ----------------------------------------------------------------------------
module wavelet_coefficient_shrinkage import wcs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // coef_in[15:0], col[27:16], row[39:28]
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,   // coef_out[15:0]
	output logic                  m_axis_tuser,   // is_detail[0]
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t              cfg_q;
	logic              f_valid, f_ready;
	item_t             f_item;
	logic [SQ_W-1:0]   f_sq;
	logic              d_valid, d_ready;
	item_t             d_item;
	logic [Q_W-1:0]    d_quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= RST_WIDTH;
			cfg_q.height <= RST_HEIGHT;
			cfg_q.level  <= RST_LEVEL;
			cfg_q.thresh <= RST_THRESH;
			cfg_q.mode   <= MODE_HARD;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_WIDTH:  cfg_q.width  <= cfg_data[DIM_W-1:0];
				CFG_HEIGHT: cfg_q.height <= cfg_data[DIM_W-1:0];
				CFG_LEVEL:  cfg_q.level  <= cfg_data[LVL_W-1:0];
				CFG_THRESH: cfg_q.thresh <= cfg_data[THR_W-1:0];
				CFG_MODE:   cfg_q.mode   <= cfg_data[MODE_W-1:0];
				default:    ;
			endcase
		end
	end

	wcs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_item  (f_item),
		.out_sq    (f_sq)
	);

	wcs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_item   (f_item),
		.in_sq     (f_sq),
		.out_valid (d_valid),
		.out_ready (d_ready),
		.out_item  (d_item),
		.out_quot  (d_quot)
	);

	wcs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (d_valid),
		.in_ready   (d_ready),
		.in_item    (d_item),
		.in_quot    (d_quot),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (m_axis_tdata),
		.out_detail (m_axis_tuser)
	);

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// Wavelet coefficient shrinkage - testbench
// Streams coefficients with positions through the block under a series of
// register settings. A directed table covers band edges, threshold edges,
// every shrink mode and degenerate image sizes; random phases then follow.
// Every result is checked against its table entry or a local shrinkage
// predictor, with random input gaps and random output back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
	import wcs_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED     = 2'd3;
	localparam int                NUM_PHASES      = 12;
	localparam int                ITEMS_PER_PHASE = 63;
	localparam int                CYCLE_LIMIT     = 400000;
	localparam int                MAX_REPORTS     = 40;

	typedef struct packed {
		logic [COEF_W-1:0] coef;
		logic              detail;
	} shrunk_t;

	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_PRED,
		ROW_TYPED
	} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		cfg_idx_t          idx;
		logic [DIM_W-1:0]  val;
		logic [COEF_W-1:0] coef;
		logic [POS_W-1:0]  col;
		logic [POS_W-1:0]  row;
		logic [COEF_W-1:0] exp_coef;
		logic              exp_detail;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  cfg_we;
	cfg_idx_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	cfg_t    live_cfg;
	shrunk_t pending_q [$];
	bit      tx_burst;
	bit      rx_burst;
	int      n_errors;
	int      n_sent;
	int      n_results;
	int      n_settings;
	int      n_approx;
	int      mode_hits [4];
	int      cycles;

	dir_row_t dir_tab [$] = '{
		'{ROW_TYPED, CFG_WIDTH, 13'd0, 16'h7FFF, 12'd0, 12'd0, 16'h7FFF, 1'b0},
		'{ROW_TYPED, CFG_WIDTH, 13'd0, 16'h8000, 12'd255, 12'd255, 16'h8000, 1'b0},
		'{ROW_TYPED, CFG_WIDTH, 13'd0, 16'h8000, 12'd256, 12'd0, 16'h8000, 1'b1},
		'{ROW_TYPED, CFG_WIDTH, 13'd0, 16'h7FFF, 12'd4095, 12'd4095, 16'h7FFF, 1'b1},
		'{ROW_TYPED, CFG_WIDTH, 13'd0, 16'h0140, 12'd300, 12'd0, 16'h0000, 1'b1},
		'{ROW_TYPED, CFG_WIDTH, 13'd0, 16'h0141, 12'd0, 12'd300, 16'h0141, 1'b1},
		'{ROW_TYPED, CFG_WIDTH, 13'd0, 16'hFEC0, 12'd300, 12'd300, 16'h0000, 1'b1},
		'{ROW_TYPED, CFG_WIDTH, 13'd0, 16'hFEBF, 12'd511, 12'd511, 16'hFEBF, 1'b1},
		'{ROW_CFG, CFG_MODE, 13'(MODE_SOFT), 16'h0, 12'd0, 12'd0, 16'h0, 1'b0},
		'{ROW_PRED, CFG_WIDTH, 13'd0, 16'h0141, 12'd300, 12'd0, 16'h0, 1'b0},
		'{ROW_PRED, CFG_WIDTH, 13'd0, 16'h8000, 12'd300, 12'd0, 16'h0, 1'b0},
		'{ROW_PRED, CFG_WIDTH, 13'd0, 16'h7FFF, 12'd0, 12'd300, 16'h0, 1'b0},
		'{ROW_CFG, CFG_MODE, 13'(MODE_GARROTE), 16'h0, 12'd0, 12'd0, 16'h0, 1'b0},
		'{ROW_PRED, CFG_WIDTH, 13'd0, 16'h0280, 12'd300, 12'd0, 16'h0, 1'b0},
		'{ROW_PRED, CFG_WIDTH, 13'd0, 16'hFEBF, 12'd300, 12'd0, 16'h0, 1'b0},
		'{ROW_PRED, CFG_WIDTH, 13'd0, 16'h8000, 12'd300, 12'd0, 16'h0, 1'b0},
		'{ROW_CFG, CFG_MODE, 13'(MODE_UNUSED), 16'h0, 12'd0, 12'd0, 16'h0, 1'b0},
		'{ROW_TYPED, CFG_WIDTH, 13'd0, 16'h8000, 12'd300, 12'd0, 16'h8000, 1'b1},
		'{ROW_CFG, CFG_THRESH, 13'd2047, 16'h0, 12'd0, 12'd0, 16'h0, 1'b0},
		'{ROW_TYPED, CFG_WIDTH, 13'd0, 16'h7FFF, 12'd300, 12'd0, 16'h7FFF, 1'b1},
		'{ROW_TYPED, CFG_WIDTH, 13'd0, 16'h8001, 12'd300, 12'd0, 16'h8001, 1'b1},
		'{ROW_CFG, CFG_MODE, 13'(MODE_GARROTE), 16'h0, 12'd0, 12'd0, 16'h0, 1'b0},
		'{ROW_PRED, CFG_WIDTH, 13'd0, 16'h7FFF, 12'd300, 12'd0, 16'h0, 1'b0},
		'{ROW_PRED, CFG_WIDTH, 13'd0, 16'h8000, 12'd300, 12'd0, 16'h0, 1'b0},
		'{ROW_TYPED, CFG_WIDTH, 13'd0, 16'h7FF0, 12'd300, 12'd0, 16'h0000, 1'b1},
		'{ROW_CFG, CFG_THRESH, 13'd0, 16'h0, 12'd0, 12'd0, 16'h0, 1'b0},
		'{ROW_CFG, CFG_MODE, 13'(MODE_SOFT), 16'h0, 12'd0, 12'd0, 16'h0, 1'b0},
		'{ROW_TYPED, CFG_WIDTH, 13'd0, 16'h0001, 12'd300, 12'd0, 16'h0001, 1'b1},
		'{ROW_TYPED, CFG_WIDTH, 13'd0, 16'h0000, 12'd300, 12'd0, 16'h0000, 1'b1},
		'{ROW_CFG, CFG_WIDTH, 13'd0, 16'h0, 12'd0, 12'd0, 16'h0, 1'b0},
		'{ROW_TYPED, CFG_WIDTH, 13'd0, 16'h0064, 12'd0, 12'd0, 16'h0064, 1'b1},
		'{ROW_CFG, CFG_WIDTH, 13'd4096, 16'h0, 12'd0, 12'd0, 16'h0, 1'b0},
		'{ROW_CFG, CFG_HEIGHT, 13'd4096, 16'h0, 12'd0, 12'd0, 16'h0, 1'b0},
		'{ROW_CFG, CFG_LEVEL, 13'd0, 16'h0, 12'd0, 12'd0, 16'h0, 1'b0},
		'{ROW_TYPED, CFG_WIDTH, 13'd0, 16'h8000, 12'd4095, 12'd4095, 16'h8000, 1'b0},
		'{ROW_CFG, CFG_LEVEL, 13'd15, 16'h0, 12'd0, 12'd0, 16'h0, 1'b0},
		'{ROW_TYPED, CFG_WIDTH, 13'd0, 16'h8000, 12'd0, 12'd0, 16'h8000, 1'b1}
	};

	wavelet_coefficient_shrinkage u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned band_limit(logic [DIM_W-1:0] size);
		return 32'(size) >> live_cfg.level;
	endfunction

	function automatic shrunk_t shrink_predict(logic [COEF_W-1:0] raw, logic [POS_W-1:0] col,
			logic [POS_W-1:0] row);
		int unsigned     mag;
		int unsigned     thr;
		int unsigned     m;
		longint unsigned corr;
		logic            neg;
		shrunk_t         r;
		neg = raw[COEF_W-1];
		mag = neg ? 32'h10000 - 32'(raw) : 32'(raw);
		thr = 32'(live_cfg.thresh) << FRAC_BITS;
		r.detail = (32'(col) >= band_limit(live_cfg.width)) ||
			(32'(row) >= band_limit(live_cfg.height));
		if (!r.detail) begin
			r.coef = raw;
			return r;
		end
		if (mag <= thr) begin
			m = 0;
		end else begin
			case (live_cfg.mode)
				MODE_SOFT: begin
					m = mag - thr;
				end
				MODE_GARROTE: begin
					corr = (64'(thr) * 64'(thr)) / 64'(mag);
					m = mag - 32'(corr);
				end
				default: begin
					m = mag;
				end
			endcase
		end
		r.coef = neg ? COEF_W'(32'h10000 - m) : COEF_W'(m);
		return r;
	endfunction

	task automatic flag_mismatch(string what, int got, int want);
		n_errors++;
		if (n_errors <= MAX_REPORTS)
			$display("[%0t] %s: got 0x%0h expected 0x%0h", $time, what, got, want);
	endtask

	// caller sits at a falling edge; returns at a falling edge
	task automatic write_reg(cfg_idx_t idx, logic [DIM_W-1:0] val);
		s_axis_tvalid <= 1'b0;
		while (pending_q.size() != 0)
			@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		case (idx)
			CFG_WIDTH:  live_cfg.width  = val;
			CFG_HEIGHT: live_cfg.height = val;
			CFG_LEVEL:  live_cfg.level  = val[LVL_W-1:0];
			CFG_THRESH: live_cfg.thresh = val[THR_W-1:0];
			CFG_MODE:   live_cfg.mode   = val[MODE_W-1:0];
			default:    ;
		endcase
		n_settings++;
	endtask

	task automatic send_coef(logic [COEF_W-1:0] coef, logic [POS_W-1:0] col,
			logic [POS_W-1:0] row, bit typed, shrunk_t typed_exp);
		int      gap;
		shrunk_t want;
		gap = tx_burst ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {row, col, coef};
		want = typed ? typed_exp : shrink_predict(coef, col, row);
		do @(posedge clk); while (!s_axis_tready);
		pending_q.push_back(want);
		n_sent++;
		if (want.detail)
			mode_hits[live_cfg.mode]++;
		else
			n_approx++;
		@(negedge clk);
	endtask

	function automatic logic [COEF_W-1:0] pick_coef(int unsigned thr);
		int m;
		case ($urandom_range(0, 7))
			0, 1: return COEF_W'($urandom);
			2: begin
				case ($urandom_range(0, 3))
					0:       return 16'h0000;
					1:       return 16'h7FFF;
					2:       return 16'h8000;
					default: return 16'hFFFF;
				endcase
			end
			default: begin
				m = int'(thr) + int'($urandom_range(0, 64)) - 32;
				if ($urandom_range(0, 3) == 0)
					m = int'(thr) + int'($urandom_range(0, 4096));
				if (m < 0)
					m = 0;
				if (m > 32768)
					m = 32768;
				return ($urandom_range(0, 1) != 0) ? COEF_W'(-m) : COEF_W'(m);
			end
		endcase
	endfunction

	function automatic logic [POS_W-1:0] pick_pos(int unsigned lim);
		int p;
		case ($urandom_range(0, 2))
			0: return POS_W'($urandom_range(0, 4095));
			1: p = int'(lim) + int'($urandom_range(0, 8)) - 4;
			default: p = (lim == 0) ? 0 : int'($urandom_range(0, lim - 1));
		endcase
		if (p < 0)
			p = 0;
		if (p > 4095)
			p = 4095;
		return POS_W'(p);
	endfunction

	initial begin
		int unsigned w, h, lvl, thr, md;
		shrunk_t     typed_exp;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_WIDTH;
		cfg_data      = '0;
		arst_n        = 1'b0;
		live_cfg      = '{RST_WIDTH, RST_HEIGHT, RST_LEVEL, RST_THRESH, MODE_HARD};
		tx_burst      = 1'b0;
		rx_burst      = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_CFG) begin
				write_reg(dir_tab[i].idx, dir_tab[i].val);
			end else begin
				typed_exp = '{dir_tab[i].exp_coef, dir_tab[i].exp_detail};
				send_coef(dir_tab[i].coef, dir_tab[i].col, dir_tab[i].row,
					dir_tab[i].kind == ROW_TYPED, typed_exp);
			end
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin w = 1;    h = 4096; lvl = 0;  thr = 0;    md = MODE_HARD;    end
				1: begin w = 4096; h = 1;    lvl = 12; thr = 2047; md = MODE_SOFT;    end
				2: begin w = 8191; h = 8191; lvl = 1;  thr = 2047; md = MODE_GARROTE; end
				3: begin w = 0;    h = 512;  lvl = 15; thr = 1;    md = MODE_UNUSED;  end
				default: begin
					w   = $urandom_range(1, 4096);
					h   = $urandom_range(1, 4096);
					lvl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
						: $urandom_range(0, 4);
					thr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
						: $urandom_range(0, 200);
					md  = $urandom_range(0, 3);
				end
			endcase
			write_reg(CFG_WIDTH, DIM_W'(w));
			write_reg(CFG_HEIGHT, DIM_W'(h));
			write_reg(CFG_LEVEL, DIM_W'(lvl));
			write_reg(CFG_THRESH, DIM_W'(thr));
			write_reg(CFG_MODE, DIM_W'(md));
			tx_burst = ($urandom_range(0, 3) == 0);
			rx_burst = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				send_coef(pick_coef(32'(live_cfg.thresh) << FRAC_BITS),
					pick_pos(band_limit(live_cfg.width)),
					pick_pos(band_limit(live_cfg.height)), 1'b0, '0);
			end
		end

		s_axis_tvalid <= 1'b0;
		while (pending_q.size() != 0)
			@(negedge clk);
		repeat (24) @(negedge clk);
		$display("%0d coefficients, %0d results, %0d register writes; %0d approximation",
			n_sent, n_results, n_settings, n_approx);
		$display("detail by mode: hard %0d soft %0d garrote %0d unused %0d",
			mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
		if (n_errors == 0)
			$display("wavelet_coefficient_shrinkage: match");
		else
			$display("wavelet_coefficient_shrinkage: mismatch");
		$finish;
	end

	// output side back-pressure
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			stall = rx_burst ? 0 : $urandom_range(0, 17);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
		end
	end

	always @(posedge clk) begin : result_check
		shrunk_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_results++;
			if (pending_q.size() == 0) begin
				flag_mismatch("result with nothing pending", m_axis_tdata, 0);
			end else begin
				want = pending_q.pop_front();
				if (m_axis_tdata !== want.coef)
					flag_mismatch("coef_out", m_axis_tdata, want.coef);
				if (m_axis_tuser !== want.detail)
					flag_mismatch("is_detail", m_axis_tuser, want.detail);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout with %0d results outstanding", pending_q.size());
			$display("wavelet_coefficient_shrinkage: mismatch");
			$finish;
		end
	end

endmodule
